// File: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and codes for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEF_CAPACITY = 16;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] item_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic               found;
        logic [3:0]         match_position;
        logic [1:0]         status;
        logic               is_empty;
        logic [4:0]         element_count;
    } out_word_t;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic shift_back;   // insert at front: all entries move one place back
        logic shift_front;  // remove at front: all entries move one place forward
        logic load_tail;    // insert at back: first empty cell takes the value
        logic mark_key;     // tag cells whose entry equals the key
        logic mark_tail;    // tag the last entry and drop it
        logic scan;         // tags and carried values move one cell forward
    } cell_ctrl_t;

endpackage

// File: rtl/bounded_deque_with_search.sv
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded double-ended queue of signed 32-bit words with linear search.
// ----------------------------------------------------------------------------
// Entries sit in a chain of CAPACITY cells, front entry in cell 0. Inserts at
// either end and removal from the front update the chain when the word is
// accepted. A search compares all cells at once, then walks the match flags
// forward one cell a cycle until a flag reaches cell 0 or the scan runs past
// the last entry. Removal from the back tags the last entry and moves its
// value forward the same way. One word is in work at a time, and the input
// side stalls while a finished result waits in the result register.
module bounded_deque_with_search
    import bdq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic            scan_search_reg, scan_search_next;
    logic            out_valid_reg, out_valid_next;
    out_word_t       out_reg, out_next;

    cell_ctrl_t         ctrl;
    logic signed [31:0] data_w  [CAPACITY];
    logic               valid_w [CAPACITY];
    logic               tag_w   [CAPACITY];
    logic signed [31:0] cval_w  [CAPACITY];

    logic accept, out_free, full, empty, scan_done;

    function automatic out_word_t make_out(
        input logic signed [31:0] removed,
        input logic               hit,
        input logic [CW-1:0]      pos,
        input logic [1:0]         stat,
        input logic [CW-1:0]      cnt
    );
        out_word_t w;
        w.removed_value  = removed;
        w.found          = hit;
        w.match_position = 4'(pos);
        w.status         = stat;
        w.is_empty       = (cnt == '0);
        w.element_count  = 5'(cnt);
        return w;
    endfunction

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] prev_data, next_data, next_cval;
        logic               prev_valid, next_valid, next_tag;

        if (i == 0)
        begin : g_head
            assign prev_data  = in_word.item_value;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_body
            assign prev_data  = data_w[i-1];
            assign prev_valid = valid_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_data  = '0;
            assign next_valid = 1'b0;
            assign next_tag   = 1'b0;
            assign next_cval  = '0;
        end
        else
        begin : g_mid
            assign next_data  = data_w[i+1];
            assign next_valid = valid_w[i+1];
            assign next_tag   = tag_w[i+1];
            assign next_cval  = cval_w[i+1];
        end

        bdq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .word_value (in_word.item_value),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .next_data  (next_data),
            .next_valid (next_valid),
            .next_tag   (next_tag),
            .next_cval  (next_cval),
            .data       (data_w[i]),
            .valid      (valid_w[i]),
            .tag        (tag_w[i]),
            .cval       (cval_w[i])
        );
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(CAPACITY));
    assign empty    = (count_reg == '0);

    // match flag has reached the front, or a search ran past the last entry
    assign scan_done = tag_w[0] ||
        (scan_search_reg && (({1'b0, scan_cnt_reg} + 1'b1) >= {1'b0, count_reg}));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        scan_cnt_next    = scan_cnt_reg;
        scan_search_next = scan_search_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_next         = out_reg;
        ctrl             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_word.op) inside
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                out_next = make_out('0, 1'b0, '0, ST_FULL, count_reg);
                            end
                            else
                            begin
                                ctrl.shift_back = (in_word.op == OP_PUSH_FRONT);
                                ctrl.load_tail  = (in_word.op == OP_PUSH_BACK);
                                count_next      = count_reg + 1'b1;
                                out_next = make_out('0, 1'b0, '0, ST_OK, count_next);
                            end
                            out_valid_next = 1'b1;
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_next = make_out('0, 1'b0, '0, ST_EMPTY, count_reg);
                            end
                            else
                            begin
                                ctrl.shift_front = 1'b1;
                                count_next       = count_reg - 1'b1;
                                out_next = make_out(data_w[0], 1'b0, '0, ST_OK, count_next);
                            end
                            out_valid_next = 1'b1;
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_next = make_out('0, 1'b0, '0, ST_EMPTY, count_reg);
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.mark_tail   = 1'b1;
                                count_next       = count_reg - 1'b1;
                                scan_cnt_next    = '0;
                                scan_search_next = 1'b0;
                                state_next       = S_SCAN;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (empty)
                            begin
                                out_next = make_out('0, 1'b0, '0, ST_OK, count_reg);
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.mark_key    = 1'b1;
                                scan_cnt_next    = '0;
                                scan_search_next = 1'b1;
                                state_next       = S_SCAN;
                            end
                        end
                        default:
                        begin
                            out_next = make_out('0, 1'b0, '0, ST_OK, count_reg);
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    if (out_free)
                    begin
                        if (scan_search_reg)
                        begin
                            out_next = make_out('0, tag_w[0],
                                tag_w[0] ? scan_cnt_reg : '0, ST_OK, count_reg);
                        end
                        else
                        begin
                            out_next = make_out(cval_w[0], 1'b0, '0, ST_OK, count_reg);
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    ctrl.scan     = 1'b1;
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            scan_cnt_reg    <= '0;
            scan_search_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            scan_cnt_reg    <= scan_cnt_next;
            scan_search_reg <= scan_search_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// File: rtl/bdq_cell.sv
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque chain: entry, valid flag and scan carrier.
// ----------------------------------------------------------------------------
module bdq_cell
    import bdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic signed [31:0] word_value,
    input  logic signed [31:0] prev_data,
    input  logic               prev_valid,
    input  logic signed [31:0] next_data,
    input  logic               next_valid,
    input  logic               next_tag,
    input  logic signed [31:0] next_cval,
    output logic signed [31:0] data,
    output logic               valid,
    output logic               tag,
    output logic signed [31:0] cval
);

    logic signed [31:0] data_reg, data_next;
    logic               valid_reg, valid_next;
    logic               tag_reg, tag_next;
    logic signed [31:0] cval_reg, cval_next;
    logic               tail;

    assign tail = valid_reg && !next_valid;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        tag_next   = tag_reg;
        cval_next  = cval_reg;
        if (ctrl.shift_back)
        begin
            data_next  = prev_data;
            valid_next = prev_valid;
        end
        else if (ctrl.shift_front)
        begin
            data_next  = next_data;
            valid_next = next_valid;
        end
        else if (ctrl.load_tail)
        begin
            if (!valid_reg && prev_valid)
            begin
                data_next  = word_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.mark_key)
        begin
            tag_next = valid_reg && (data_reg == word_value);
        end
        else if (ctrl.mark_tail)
        begin
            tag_next   = tail;
            cval_next  = data_reg;
            valid_next = valid_reg && !tail;
        end
        else if (ctrl.scan)
        begin
            tag_next  = next_tag;
            cval_next = next_cval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tag_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            tag_reg   <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        cval_reg <= cval_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign tag   = tag_reg;
    assign cval  = cval_reg;

endmodule
